// ===== rtl/core/lrgs_pkg.sv =====
// Shared types and constants for the Life row generation step block.
`default_nettype none
package lrgs_pkg;
    localparam int ROW_WIDTH         = 64;
    localparam int ROW_CELLS_DEFAULT = 64;
    localparam int OUT_DEPTH         = 4;
    localparam int BIRTH_COUNT       = 3;
    localparam int SURVIVE_COUNT     = 2;

    typedef struct packed {
        logic [ROW_WIDTH-1:0] row_cells;
        logic                 last_row;
    } in_word_t;

    typedef struct packed {
        logic [ROW_WIDTH-1:0] next_row;
        logic                 frame_end;
    } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/core/lrgs_cell_lane.sv =====
// One cell lane: neighbour count and B3/S23 rule for a single cell.
`default_nettype none
module lrgs_cell_lane
    import lrgs_pkg::*;
(
    input  wire logic [2:0] above,
    input  wire logic [2:0] here,
    input  wire logic [2:0] below,
    output logic            alive_next
);
    logic [3:0] count;

    always_comb begin
        count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
              + 4'(here[0])  + 4'(here[2])
              + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
        alive_next = (count == 4'(BIRTH_COUNT))
                   || (here[1] && (count == 4'(SURVIVE_COUNT)));
    end
endmodule
`default_nettype wire

// ===== rtl/core/lrgs_row_gen.sv =====
// Row of cell lanes producing the next generation of one row.
`default_nettype none
module lrgs_row_gen
    import lrgs_pkg::*;
#(
    parameter int ROW_CELLS = ROW_CELLS_DEFAULT
) (
    input  wire logic [ROW_WIDTH-1:0] above,
    input  wire logic [ROW_WIDTH-1:0] here,
    input  wire logic [ROW_WIDTH-1:0] below,
    output logic      [ROW_WIDTH-1:0] next_row
);
    logic [ROW_CELLS+1:0] above_pad;
    logic [ROW_CELLS+1:0] here_pad;
    logic [ROW_CELLS+1:0] below_pad;
    logic [ROW_CELLS-1:0] lane_alive;

    assign above_pad = {1'b0, above[ROW_CELLS-1:0], 1'b0};
    assign here_pad  = {1'b0, here[ROW_CELLS-1:0], 1'b0};
    assign below_pad = {1'b0, below[ROW_CELLS-1:0], 1'b0};

    for (genvar x = 0; x < ROW_CELLS; x++) begin : g_lane
        lrgs_cell_lane u_lane (
            .above      (above_pad[x+2:x]),
            .here       (here_pad[x+2:x]),
            .below      (below_pad[x+2:x]),
            .alive_next (lane_alive[x])
        );
    end

    assign next_row = ROW_WIDTH'(lane_alive);
endmodule
`default_nettype wire

// ===== rtl/core/lrgs_out_queue.sv =====
// Small result queue taking up to two words per cycle and giving one.
`default_nettype none
module lrgs_out_queue
    import lrgs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic [1:0] push_count,
    input  wire out_word_t push_word0,
    input  wire out_word_t push_word1,
    output logic           has_room,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);
    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    out_word_t          entry_reg [OUT_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign pop          = m_valid && m_ready;
    assign m_valid      = count_reg != '0;
    assign m_data       = entry_reg[rd_ptr_reg];
    assign has_room     = count_reg <= CNT_W'(OUT_DEPTH - 2);
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_word0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push_word1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/life_row_generation_step.sv =====
// Top level: streaming Conway Life (B3/S23) generation step, one row per word.
//
// Input words (s_valid/s_ready/s_data) carry one grid row each, top to bottom,
// with last_row set on the bottom row. Cells outside the grid count as dead.
// Result words (m_valid/m_ready/m_data) carry next generations: each row after
// the first yields the next generation of the row above it, and the bottom row
// also yields its own, marked by frame_end, so it gives two words. A one-row
// frame gives a single word.
// Throughput: one input word per cycle while s_ready is high; a bottom row
// gives two output words. Each result enters the output queue on accept.
// Two copies of the row of cell lanes evaluate both possible results in the
// accept cycle, and a four-word output queue decouples the two sides; s_ready
// drops while fewer than two queue slots are free.
// Reset (aresetn low, synchronous) empties the queue and clears the held rows.
// When the receiver stalls, the queue fills and s_ready falls; nothing is lost.
`default_nettype none
module life_row_generation_step
    import lrgs_pkg::*;
#(
    parameter int ROW_CELLS = ROW_CELLS_DEFAULT
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);
    localparam logic [ROW_WIDTH-1:0] ROW_MASK = ROW_WIDTH'({ROW_CELLS{1'b1}});

    logic [ROW_WIDTH-1:0] upper_reg,  upper_next;
    logic [ROW_WIDTH-1:0] middle_reg, middle_next;
    logic                 middle_valid_reg, middle_valid_next;
    logic [ROW_WIDTH-1:0] row_in;
    logic [ROW_WIDTH-1:0] gen_above;
    logic [ROW_WIDTH-1:0] gen_last;
    logic                 accept;
    logic                 has_room;
    logic [1:0]           push_count;
    out_word_t            word_above;
    out_word_t            word_last;
    out_word_t            push_word0;

    assign row_in  = s_data.row_cells & ROW_MASK;
    assign s_ready = has_room;
    assign accept  = s_valid && s_ready;

    lrgs_row_gen #(.ROW_CELLS(ROW_CELLS)) u_gen_above (
        .above    (upper_reg),
        .here     (middle_reg),
        .below    (row_in),
        .next_row (gen_above)
    );

    lrgs_row_gen #(.ROW_CELLS(ROW_CELLS)) u_gen_last (
        .above    (middle_reg),
        .here     (row_in),
        .below    ('0),
        .next_row (gen_last)
    );

    always_comb begin
        word_above.next_row  = gen_above;
        word_above.frame_end = 1'b0;
        word_last.next_row   = gen_last;
        word_last.frame_end  = 1'b1;
        push_word0           = middle_valid_reg ? word_above : word_last;
        push_count           = 2'b00;
        if (accept) begin
            push_count = 2'(middle_valid_reg) + 2'(s_data.last_row);
        end
    end

    always_comb begin
        upper_next        = upper_reg;
        middle_next       = middle_reg;
        middle_valid_next = middle_valid_reg;
        if (accept) begin
            if (s_data.last_row) begin
                upper_next        = '0;
                middle_next       = '0;
                middle_valid_next = 1'b0;
            end else begin
                upper_next        = middle_reg;
                middle_next       = row_in;
                middle_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg        <= '0;
            middle_reg       <= '0;
            middle_valid_reg <= 1'b0;
        end else begin
            upper_reg        <= upper_next;
            middle_reg       <= middle_next;
            middle_valid_reg <= middle_valid_next;
        end
    end

    lrgs_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_word0 (push_word0),
        .push_word1 (word_last),
        .has_room   (has_room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );
endmodule
`default_nettype wire
